[sv/fifc_pkg.sv]
// Shared types, constants and CRC/header functions for the boot image framer.
// No dependencies; imported by the interface file and every module.
package fifc_pkg;

	localparam int HEADER_BYTES  = 44;
	localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
	localparam int HDR_CRC_BYTES = HEADER_BYTES - 4;
	localparam int LEN_W         = 29;
	localparam int WORD_W        = 32;
	localparam int CFG_IDX_W     = 2;

	localparam logic [WORD_W-1:0] IMG_MAGIC = 32'h4C44_524B;
	localparam logic [WORD_W-1:0] IMG_BASE  = 32'h6000_0000;
	localparam logic [WORD_W-1:0] IMG_PTR   = 32'h6035_A5E4;
	localparam logic [WORD_W-1:0] IMG_FLAGS = 32'hE000_0000;
	localparam logic [WORD_W-1:0] CRC_POLY  = 32'h04C1_0DB7;

	localparam logic [CFG_IDX_W-1:0] CFG_MODEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;

	localparam logic [3:0] W_MAGIC = 4'd0;
	localparam logic [3:0] W_SIZE  = 4'd1;
	localparam logic [3:0] W_BASE  = 4'd2;
	localparam logic [3:0] W_LOAD  = 4'd3;
	localparam logic [3:0] W_END   = 4'd4;
	localparam logic [3:0] W_PTR   = 4'd5;
	localparam logic [3:0] W_MODEL = 4'd6;
	localparam logic [3:0] W_ZERO  = 4'd7;
	localparam logic [3:0] W_ENTRY = 4'd8;
	localparam logic [3:0] W_FLAGS = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_HBYTE,
		ST_BYTE,
		ST_TRL
	} state_t;

	typedef struct packed {
		logic load;
		logic hdr_start;
		logic emit_hdr;
		logic emit_byte;
		logic byte_last;
		logic set_pend;
		logic emit_trl;
	} cmd_t;

	typedef struct packed {
		logic in_frame;
		logic pend;
		logic hdr_last;
		logic trl_last;
		logic len_hit;
		logic out_free;
	} status_t;

	function automatic logic [WORD_W-1:0] crc_update(input logic [WORD_W-1:0] crc,
			input logic [7:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[WORD_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] hdr_word(input logic [3:0] sel,
			input logic [WORD_W-1:0] model, input logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] w;
		case (sel)
			W_MAGIC: w = IMG_MAGIC;
			W_SIZE:  w = WORD_W'(HEADER_BYTES);
			W_BASE:  w = IMG_BASE;
			W_LOAD:  w = IMG_BASE;
			W_END:   w = IMG_BASE + {{(WORD_W-LEN_W){1'b0}}, len};
			W_PTR:   w = IMG_PTR;
			W_MODEL: w = model;
			W_ZERO:  w = '0;
			W_ENTRY: w = IMG_BASE;
			W_FLAGS: w = IMG_FLAGS;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[sv/fifc_if.sv]
// Valid/ready channel interfaces: payload input, framed image output, config writes.
// Depends on fifc_pkg for field widths.
interface fifc_in_if;
	import fifc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface fifc_out_if;
	import fifc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	modport source (output valid, output out_byte, output run_last, output frame_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input frame_end,
		output ready);
endinterface

interface fifc_cfg_if;
	import fifc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/firmware_image_framer_crc_top.sv]
// Boot image framer top level: joins controller and datapath to the channels.
// Depends on fifc_pkg, fifc_if, fifc_ctrl and fifc_dp.
//
// One payload byte is taken per transaction and at most one framed byte leaves
// per cycle. A byte inside a frame is accepted, then emitted; the first byte of
// a frame is preceded by the 44 header bytes, and the byte that completes the
// length is followed by the 4 trailer bytes. The controller handles one
// transaction at a time through a single output register, taking no new byte
// until the last is emitted. For one-byte frames the trailer goes out on the
// following input transaction, whose byte is dropped. model_number and
// payload_length are written at config indexes 0 and 1, which the user must do
// only while idle; the block does not enforce it. The header reads them live.
module firmware_image_framer_crc_top (
	input  logic       clk,
	input  logic       arst_n,
	fifc_in_if.sink    payload,
	fifc_out_if.source image,
	fifc_cfg_if.sink   cfg
);
	import fifc_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    in_ready;

	assign payload.ready = in_ready;

	fifc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (payload.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	fifc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (payload.in_byte),
		.cmd     (cmd),
		.st      (st),
		.image   (image),
		.cfg     (cfg)
	);

endmodule

[sv/fifc_ctrl.sv]
// Framer controller: sequences header, payload byte and trailer emission.
// Depends on fifc_pkg for state, command and status types.
module fifc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fifc_pkg::status_t st,
	output fifc_pkg::cmd_t    cmd
);
	import fifc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.pend) begin
						state_d = ST_TRL;
					end else if (!st.in_frame) begin
						state_d = ST_HDR;
					end else begin
						state_d = ST_BYTE;
					end
				end
			end
			ST_HDR: begin
				if (st.out_free && st.hdr_last) begin
					state_d = ST_HBYTE;
				end
			end
			ST_HBYTE: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BYTE: begin
				if (st.out_free) begin
					state_d = st.len_hit ? ST_TRL : ST_IDLE;
				end
			end
			ST_TRL: begin
				if (st.out_free && st.trl_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load      = in_valid;
				cmd.hdr_start = in_valid && !st.pend && !st.in_frame;
			end
			ST_HDR: begin
				cmd.emit_hdr = st.out_free;
			end
			ST_HBYTE: begin
				cmd.emit_byte = st.out_free;
				cmd.byte_last = 1'b1;
				cmd.set_pend  = st.out_free && st.len_hit;
			end
			ST_BYTE: begin
				cmd.emit_byte = st.out_free;
				cmd.byte_last = !st.len_hit;
			end
			ST_TRL: begin
				cmd.emit_trl = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_hdr, cmd.emit_byte, cmd.emit_trl}))
		else $error("more than one emit command at once");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_hdr || cmd.emit_byte || cmd.emit_trl) |-> st.out_free)
		else $error("emit while output register is occupied");

endmodule

[sv/fifc_dp.sv]
// Framer datapath: config registers, header/payload CRC, counters, output register.
// Depends on fifc_pkg and the channel interfaces in fifc_if.
module fifc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  fifc_pkg::cmd_t   cmd,
	output fifc_pkg::status_t st,
	fifc_out_if.source       image,
	fifc_cfg_if.sink         cfg
);
	import fifc_pkg::*;

	logic [WORD_W-1:0]    model_q;
	logic [LEN_W-1:0]     len_q;
	logic [7:0]           byte_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	logic [1:0]           trl_idx_q;
	logic [WORD_W-1:0]    hcrc_q;
	logic [WORD_W-1:0]    crc_q;
	logic [LEN_W-1:0]     cnt_q;
	logic                 in_frame_q;
	logic                 pend_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 run_last_q;
	logic                 frame_end_q;

	logic [WORD_W-1:0] hword;
	logic [7:0]        hbyte;
	logic [7:0]        tbyte;
	logic [LEN_W-1:0]  cnt_inc;
	logic              hdr_in_crc;
	logic              emit_any;

	assign cfg.ready  = 1'b1;
	assign hdr_in_crc = hdr_idx_q < HDR_IDX_W'(HDR_CRC_BYTES);
	assign hword      = hdr_in_crc ? hdr_word(hdr_idx_q[HDR_IDX_W-1:2], model_q, len_q)
	                               : hcrc_q;
	assign hbyte      = 8'(hword >> {hdr_idx_q[1:0], 3'b000});
	assign tbyte      = 8'(crc_q >> {trl_idx_q, 3'b000});
	assign cnt_inc    = cnt_q + LEN_W'(1);
	assign emit_any   = cmd.emit_hdr || cmd.emit_byte || cmd.emit_trl;

	assign st.in_frame = in_frame_q;
	assign st.pend     = pend_q;
	assign st.hdr_last = hdr_idx_q == HDR_IDX_W'(HEADER_BYTES - 1);
	assign st.trl_last = trl_idx_q == 2'd3;
	assign st.len_hit  = cnt_inc == len_q;
	assign st.out_free = !out_valid_q || image.ready;

	assign image.valid     = out_valid_q;
	assign image.out_byte  = out_byte_q;
	assign image.run_last  = run_last_q;
	assign image.frame_end = frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= '0;
			len_q   <= LEN_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MODEL:  model_q <= cfg.data;
				CFG_LENGTH: len_q   <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q   <= '0;
			trl_idx_q   <= '0;
			hcrc_q      <= '0;
			crc_q       <= '0;
			cnt_q       <= '0;
			in_frame_q  <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.hdr_start) begin
				hdr_idx_q  <= '0;
				hcrc_q     <= '0;
				crc_q      <= '0;
				cnt_q      <= '0;
				in_frame_q <= 1'b1;
			end
			if (cmd.emit_hdr) begin
				hdr_idx_q <= hdr_idx_q + HDR_IDX_W'(1);
				if (hdr_in_crc) begin
					hcrc_q <= crc_update(hcrc_q, hbyte);
				end
			end
			if (cmd.emit_byte) begin
				crc_q <= crc_update(crc_q, byte_q);
				cnt_q <= cnt_inc;
			end
			if (cmd.set_pend) begin
				pend_q <= 1'b1;
			end
			if (cmd.emit_trl) begin
				trl_idx_q <= trl_idx_q + 2'd1;
				if (st.trl_last) begin
					in_frame_q <= 1'b0;
					pend_q     <= 1'b0;
				end
			end
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (image.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
		end
		if (cmd.emit_hdr) begin
			out_byte_q  <= hbyte;
			run_last_q  <= 1'b0;
			frame_end_q <= 1'b0;
		end else if (cmd.emit_byte) begin
			out_byte_q  <= byte_q;
			run_last_q  <= cmd.byte_last;
			frame_end_q <= 1'b0;
		end else if (cmd.emit_trl) begin
			out_byte_q  <= tbyte;
			run_last_q  <= st.trl_last;
			frame_end_q <= st.trl_last;
		end
	end

	a_pend_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> in_frame_q)
		else $error("trailer pending outside a frame");

	a_trl_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_trl |-> in_frame_q)
		else $error("trailer emitted outside a frame");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q)
		else $error("frame end without run last");

endmodule

[test/fifc_checker.sv]
// Checker for the boot image framer: tracks config writes, predicts the framed byte stream.
// Compares every accepted image transaction. Depends on fifc_pkg and fifc_if.
`timescale 1ns / 1ps
module fifc_checker (
	input  logic clk,
	input  logic arst_n,
	fifc_in_if   payload,
	fifc_out_if  image,
	fifc_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	import fifc_pkg::*;

	localparam int STEP_LIMIT = 45;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_end;
	} image_beat_t;

	image_beat_t       image_due[$];
	logic [WORD_W-1:0] model_q;
	logic [LEN_W-1:0]  length_q;
	logic [WORD_W-1:0] payload_crc;
	logic [LEN_W-1:0]  bytes_seen;
	logic              frame_open;
	logic              trailer_held;

	function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] c,
			input logic [7:0] b);
		c = c ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[WORD_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 50) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic push_beat(input logic [7:0] d, input logic fend);
		image_due.push_back('{data: d, run_last: 1'b0, frame_end: fend});
	endtask

	task automatic push_trailer();
		for (int i = 0; i < 4; i++) begin
			push_beat(payload_crc[8*i +: 8], i == 3);
		end
		frame_open   = 1'b0;
		trailer_held = 1'b0;
	endtask

	task automatic frame_payload_byte(input logic [7:0] b);
		logic [WORD_W-1:0] hdr_words [10];
		logic [WORD_W-1:0] hdr_crc;
		logic [7:0]        hb;
		image_beat_t       tail;
		int                n;
		n = 0;
		if (trailer_held) begin
			push_trailer();
		end else begin
			if (!frame_open) begin
				hdr_words[0] = IMG_MAGIC;
				hdr_words[1] = WORD_W'(HEADER_BYTES);
				hdr_words[2] = IMG_BASE;
				hdr_words[3] = IMG_BASE;
				hdr_words[4] = IMG_BASE + {{(WORD_W-LEN_W){1'b0}}, length_q};
				hdr_words[5] = IMG_PTR;
				hdr_words[6] = model_q;
				hdr_words[7] = '0;
				hdr_words[8] = IMG_BASE;
				hdr_words[9] = IMG_FLAGS;
				hdr_crc = '0;
				for (int i = 0; i < 10; i++) begin
					for (int k = 0; k < 4; k++) begin
						hb = hdr_words[i][8*k +: 8];
						hdr_crc = crc_fold(hdr_crc, hb);
						push_beat(hb, 1'b0);
					end
				end
				for (int k = 0; k < 4; k++) begin
					push_beat(hdr_crc[8*k +: 8], 1'b0);
				end
				n = HEADER_BYTES;
				payload_crc = '0;
				bytes_seen  = '0;
				frame_open  = 1'b1;
			end
			push_beat(b, 1'b0);
			n++;
			payload_crc = crc_fold(payload_crc, b);
			bytes_seen  = bytes_seen + LEN_W'(1);
			if (bytes_seen == length_q) begin
				if (n + 4 > STEP_LIMIT) begin
					trailer_held = 1'b1;
				end else begin
					push_trailer();
				end
			end
		end
		tail = image_due.pop_back();
		tail.run_last = 1'b1;
		image_due.push_back(tail);
	endtask

	task automatic compare_beat();
		image_beat_t want;
		if (image_due.size() == 0) begin
			report_mismatch($sformatf("unexpected image byte %02h", image.out_byte));
		end else begin
			want = image_due.pop_front();
			if (image.out_byte !== want.data) begin
				report_mismatch($sformatf("out_byte %02h, expected %02h",
					image.out_byte, want.data));
			end
			if (image.run_last !== want.run_last) begin
				report_mismatch($sformatf("run_last %b, expected %b",
					image.run_last, want.run_last));
			end
			if (image.frame_end !== want.frame_end) begin
				report_mismatch($sformatf("frame_end %b, expected %b",
					image.frame_end, want.frame_end));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_due.delete();
			model_q      = '0;
			length_q     = LEN_W'(1);
			payload_crc  = '0;
			bytes_seen   = '0;
			frame_open   = 1'b0;
			trailer_held = 1'b0;
			fail_count   = 0;
			pending      = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MODEL: begin
						model_q = cfg.data;
					end
					CFG_LENGTH: begin
						length_q = cfg.data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (payload.valid && payload.ready) begin
				frame_payload_byte(payload.in_byte);
			end
			if (image.valid && image.ready) begin
				compare_beat();
			end
			pending = image_due.size();
		end
	end

endmodule

[test/tb_top.sv]
// Top of the boot image framer testbench: clock, reset, payload and config stimulus.
// Instantiates firmware_image_framer_crc_top and fifc_checker; gives the verdict.
`timescale 1ns / 1ps
module tb_top;
	import fifc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 230;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   mismatches;
	int   beats_open;
	int   sent = 0;
	bit   steady = 1'b0;
	bit   hold_req = 1'b0;

	fifc_in_if  payload();
	fifc_out_if image();
	fifc_cfg_if cfg();

	firmware_image_framer_crc_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.image   (image),
		.cfg     (cfg)
	);

	fifc_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.image      (image),
		.cfg        (cfg),
		.fail_count (mismatches),
		.pending    (beats_open)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		image.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				image.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				image.ready <= steady || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!steady && $urandom_range(0, 99) < 10) begin
			payload.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		payload.valid   <= 1'b1;
		payload.in_byte <= b;
		do @(posedge clk); while (!payload.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic wait_drained();
		payload.valid <= 1'b0;
		do @(posedge clk); while (beats_open != 0);
	endtask

	task automatic configure(input bit set_model, input logic [WORD_W-1:0] model,
			input logic [LEN_W-1:0] len);
		wait_drained();
		if (set_model) begin
			write_reg(CFG_MODEL, model);
		end
		write_reg(CFG_LENGTH, {{(WORD_W-LEN_W){1'b0}}, len});
		cfg.valid <= 1'b0;
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)));
			sent++;
		end
		if (len == 1) begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [WORD_W-1:0] model;
		int                len;
		int                pick;
		int                phase;
		payload.valid   = 1'b0;
		payload.in_byte = '0;
		cfg.valid       = 1'b0;
		cfg.index       = CFG_MODEL;
		cfg.data        = '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte frame at reset values; second byte only flushes the trailer
		send_byte(8'h00);
		send_byte(8'hFF);
		configure(1'b1, 32'hFFFF_FFFF, LEN_W'(2));
		send_byte(8'hFF);
		send_byte(8'h80);
		// zero length: frame stays open, then a larger length closes it
		configure(1'b1, 32'h0000_0000, LEN_W'(0));
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'hAA);
		configure(1'b0, '0, LEN_W'(5));
		send_byte(8'h55);
		send_byte(8'hC3);
		configure(1'b1, 32'h8000_0001, LEN_W'(29'h1000_0000));
		send_byte(8'hFE);
		send_byte(8'h01);
		configure(1'b0, '0, LEN_W'(3));
		send_byte(8'h10);
		configure(1'b1, $urandom(), LEN_W'(1));
		send_byte(8'h5A);
		send_byte(8'hA5);

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (phase >= 4 && phase < 7);
			pick = $urandom_range(0, 5);
			model = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				len = 1;
			end else if (pick == 2) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(2, 8);
			end
			configure(1'b1, model, LEN_W'(len));
			if (phase == 2) begin
				hold_req = 1'b1;
			end
			repeat ($urandom_range(1, 3)) send_frame(len);
			phase++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && beats_open == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
